FILE: rtl/core/pso_velocity_position_update_unit_assert.svh
// Assertion macros for the checker of the velocity and position update unit.
`ifndef PSO_VELOCITY_POSITION_UPDATE_UNIT_ASSERT_SVH
`define PSO_VELOCITY_POSITION_UPDATE_UNIT_ASSERT_SVH

// A property that is checked at every rising edge outside reset.
`define PVPU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A stalled beat keeps its payload until it is taken.
`define PVPU_ASSERT_HOLD(lbl, clk, rst, vld, stl, sig, msg) \
  `PVPU_ASSERT(lbl, clk, rst, (vld && stl) |=> $stable(sig), msg)

`endif

FILE: rtl/core/pvpu_pkg.sv
// Types, constants and register codes of the velocity and position update unit.
package pvpu_pkg;

  localparam int NSTAGE = 6;

  typedef enum logic [1:0] {
    CFG_POS_MIN = 2'd0,
    CFG_POS_MAX = 2'd1,
    CFG_VEL_MAX = 2'd2
  } cfg_idx_t;

  localparam logic signed [31:0] POS_MIN_RESET = 32'sd0;
  localparam logic signed [31:0] POS_MAX_RESET = 32'sd65536;
  localparam logic [30:0]        VEL_MAX_RESET = 31'd16384;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] personal_best;
    logic signed [31:0] swarm_best;
    logic signed [15:0] inertia;
    logic signed [15:0] cognitive_gain;
    logic signed [15:0] social_gain;
    logic [15:0]        rand_one;
    logic [15:0]        rand_two;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_position;
    logic signed [31:0] new_velocity;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] pos_min;
    logic signed [31:0] pos_max;
    logic [30:0]        vel_max;
  } cfg_t;

  typedef struct packed {
    logic [NSTAGE-1:0] load;
  } pipe_ctl_t;

  // Three Q.28 terms and the position, handed from the multiplier stages to the sum.
  typedef struct packed {
    logic signed [47:0] vw;
    logic signed [49:0] t1;
    logic signed [49:0] t2;
    logic signed [31:0] pos;
  } terms_t;

endpackage

FILE: rtl/core/pso_velocity_position_update_unit.sv
// An accepted input beat passes through the pipeline registers to its result beat on the output.
// Throughput: one beat per cycle while out_stall is low; the depth is set by the chain of two
// multipliers (difference times random factor, then times gain) and the sum and clamp stages.
// Reset (rst, synchronous) empties the pipeline and sets pos_min to 0.0, pos_max to 1.0
// and vel_max to 0.25; the configuration port is always ready.
module pso_velocity_position_update_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pvpu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pvpu_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import pvpu_pkg::*;

  cfg_t      cfg;
  pipe_ctl_t ctl;
  terms_t    terms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos_min <= POS_MIN_RESET;
      cfg.pos_max <= POS_MAX_RESET;
      cfg.vel_max <= VEL_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POS_MIN: cfg.pos_min <= cfg_data;
        CFG_POS_MAX: cfg.pos_max <= cfg_data;
        CFG_VEL_MAX: cfg.vel_max <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  pvpu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  pvpu_attract u_attract (
    .clk     (clk),
    .ctl     (ctl),
    .in_data (in_data),
    .terms   (terms)
  );

  pvpu_clamp u_clamp (
    .clk      (clk),
    .ctl      (ctl),
    .cfg      (cfg),
    .terms    (terms),
    .out_data (out_data)
  );

endmodule

FILE: rtl/core/pvpu_ctrl.sv
// Valid bits and load enables of the six pipeline stages.
module pvpu_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pvpu_pkg::pipe_ctl_t   ctl
);
  import pvpu_pkg::*;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE:0]   ready;

  // A stage can take a beat when it is empty or its own beat moves on.
  always_comb begin
    ready[NSTAGE] = !out_stall;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      ready[k] = !vld[k] || ready[k+1];
    end
  end

  assign ctl.load  = ready[NSTAGE-1:0];
  assign in_stall  = !ready[0];
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ready[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (ready[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

endmodule

FILE: rtl/core/pvpu_attract.sv
// Differences and products of the update: stages one to three.
module pvpu_attract (
  input  logic                clk,
  input  pvpu_pkg::pipe_ctl_t ctl,
  input  pvpu_pkg::in_item_t  in_data,
  output pvpu_pkg::terms_t    terms
);
  import pvpu_pkg::*;

  // Stage one
  logic signed [32:0] s1_diff1, s1_diff2;
  logic signed [47:0] s1_vw;
  logic signed [31:0] s1_pos;
  logic signed [15:0] s1_g1, s1_g2;
  logic [15:0]        s1_r1, s1_r2;
  // Stage two
  logic signed [33:0] s2_sc1, s2_sc2;
  logic signed [47:0] s2_vw;
  logic signed [31:0] s2_pos;
  logic signed [15:0] s2_g1, s2_g2;
  // Stage three
  logic signed [49:0] s3_t1, s3_t2;
  logic signed [47:0] s3_vw;
  logic signed [31:0] s3_pos;

  logic signed [49:0] prod1, prod2;

  assign prod1 = s1_diff1 * $signed({1'b0, s1_r1});
  assign prod2 = s1_diff2 * $signed({1'b0, s1_r2});

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s1_diff1 <= {in_data.personal_best[31], in_data.personal_best}
                - {in_data.position[31], in_data.position};
      s1_diff2 <= {in_data.swarm_best[31], in_data.swarm_best}
                - {in_data.position[31], in_data.position};
      s1_vw    <= in_data.velocity * in_data.inertia;
      s1_pos   <= in_data.position;
      s1_g1    <= in_data.cognitive_gain;
      s1_g2    <= in_data.social_gain;
      s1_r1    <= in_data.rand_one;
      s1_r2    <= in_data.rand_two;
    end
    // Dropping the low sixteen bits of a two's complement product rounds toward minus infinity.
    if (ctl.load[1]) begin
      s2_sc1 <= prod1[49:16];
      s2_sc2 <= prod2[49:16];
      s2_vw  <= s1_vw;
      s2_pos <= s1_pos;
      s2_g1  <= s1_g1;
      s2_g2  <= s1_g2;
    end
    if (ctl.load[2]) begin
      s3_t1  <= s2_sc1 * s2_g1;
      s3_t2  <= s2_sc2 * s2_g2;
      s3_vw  <= s2_vw;
      s3_pos <= s2_pos;
    end
  end

  assign terms.vw  = s3_vw;
  assign terms.t1  = s3_t1;
  assign terms.t2  = s3_t2;
  assign terms.pos = s3_pos;

endmodule

FILE: rtl/core/pvpu_clamp.sv
// Sum, velocity clamp and position clamp: stages four to six.
module pvpu_clamp (
  input  logic                clk,
  input  pvpu_pkg::pipe_ctl_t ctl,
  input  pvpu_pkg::cfg_t      cfg,
  input  pvpu_pkg::terms_t    terms,
  output pvpu_pkg::out_item_t out_data
);
  import pvpu_pkg::*;

  logic signed [51:0] sum;
  logic signed [39:0] s4_nv;
  logic signed [31:0] s4_pos;
  logic signed [39:0] vmax, vmin;
  logic signed [31:0] nv_clamped;
  logic signed [31:0] s5_nv, s5_pos;
  logic signed [32:0] np_sum, pmax, pmin;
  logic signed [31:0] np_clamped;
  out_item_t          s6;

  assign sum = {{4{terms.vw[47]}}, terms.vw}
             + {{2{terms.t1[49]}}, terms.t1}
             + {{2{terms.t2[49]}}, terms.t2};

  assign vmax = $signed({9'd0, cfg.vel_max});
  assign vmin = -vmax;

  always_comb begin
    if (s4_nv > vmax) begin
      nv_clamped = vmax[31:0];
    end else if (s4_nv < vmin) begin
      nv_clamped = vmin[31:0];
    end else begin
      nv_clamped = s4_nv[31:0];
    end
  end

  assign np_sum = {s5_pos[31], s5_pos} + {s5_nv[31], s5_nv};
  assign pmax   = {cfg.pos_max[31], cfg.pos_max};
  assign pmin   = {cfg.pos_min[31], cfg.pos_min};

  // When the bounds are inverted, a sum above pos_max takes pos_max and any other sum takes pos_min.
  always_comb begin
    if (np_sum > pmax) begin
      np_clamped = cfg.pos_max;
    end else if (np_sum < pmin) begin
      np_clamped = cfg.pos_min;
    end else begin
      np_clamped = np_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      s4_nv  <= sum[51:12];
      s4_pos <= terms.pos;
    end
    if (ctl.load[4]) begin
      s5_nv  <= nv_clamped;
      s5_pos <= s4_pos;
    end
    if (ctl.load[5]) begin
      s6.new_position <= np_clamped;
      s6.new_velocity <= s5_nv;
    end
  end

  assign out_data = s6;

endmodule

FILE: rtl/core/pvpu_checker.sv
// Port-level checker of the update unit and its bind to the top level.
`include "pso_velocity_position_update_unit_assert.svh"

module pvpu_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input pvpu_pkg::out_item_t out_data
);
  import pvpu_pkg::*;

  `PVPU_ASSERT(a_out_valid_held, clk, rst, (out_valid && out_stall) |=> out_valid, "stalled beat dropped")
  `PVPU_ASSERT_HOLD(a_out_data_held, clk, rst, out_valid, out_stall, out_data, "stalled beat changed")
  // The input side only stalls while a finished result is held back.
  `PVPU_ASSERT(a_stall_only_backpressure, clk, rst, !(out_valid && out_stall) |-> !in_stall, "input stalled without back-pressure")

endmodule

bind pso_velocity_position_update_unit pvpu_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
